// ----- design/hbwm_pkg.sv -----
// ----------------------------------------------------------------------------
// hbwm_pkg
// Shared types and constants for the heartbeat watchdog monitor.
// ----------------------------------------------------------------------------
package hbwm_pkg;

   typedef enum logic [2:0] {
      REASON_OK          = 3'd0,
      REASON_MAGIC_LOST  = 3'd1,
      REASON_COUNT_FROZE = 3'd2,
      REASON_ALIVE_DROP  = 3'd3,
      REASON_UPTIME_STALL = 3'd4
   } reason_type;

   // register index = byte address / 4
   localparam logic [2:0] REG_MAGIC_VALUE    = 3'd0;
   localparam logic [2:0] REG_BOOT_TIME_MS   = 3'd1;
   localparam logic [2:0] REG_BOOT_GRACE_MS  = 3'd2;
   localparam logic [2:0] REG_STALE_LIMIT_MS = 3'd3;
   localparam logic [2:0] REG_ALIVE_GRACE_MS = 3'd4;

   localparam int unsigned CSR_ADDR_WIDTH = 5;

   localparam logic [31:0] BOOT_GRACE_RESET  = 32'd8000;
   localparam logic [31:0] STALE_LIMIT_RESET = 32'd5000;
   localparam logic [31:0] ALIVE_GRACE_RESET = 32'd8000;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [31:0] magic_word;
      logic [31:0] progress_count;
      logic [31:0] alive_flags;
      logic [31:0] need_mask;
      logic [31:0] core_uptime;
   } req_type;

   typedef struct packed {
      logic [2:0]  fault_reason;
      logic [31:0] post_sequence;
   } rsp_type;

endpackage

// ----- design/heartbeat_watchdog_monitor.sv -----
// ----------------------------------------------------------------------------
// heartbeat_watchdog_monitor
// Judges polls of a heartbeat record and reports a fault reason per poll.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one poll of the heartbeat record per transaction
//   (req_valid / req_stall). rsp_* returns one transaction per poll with the
//   fault reason and the running post sequence count.
//   csr_* is an APB-style port holding the magic value, boot time, boot
//   grace, stale limit and alive grace registers at byte addresses 0..16.
//   The user must write registers only while no poll is in flight; unchecked.
// Timing:
//   A poll is captured in an input register, judged combinationally against
//   the tracker state and lands in the result register, which drives
//   rsp_valid and rsp_data. One poll per cycle is sustained while rsp_stall
//   is low; the tracker state update and the next judgment meet at the
//   single evaluate stage.
// Reset:
//   Synchronous, active high. Clears both stages, the trackers, the post
//   count and loads the register defaults.
// Stall:
//   While rsp_stall holds a result, the next judged poll waits in the input
//   register; req_stall rises only when both stages are full and rsp_stall
//   is high.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_monitor (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  hbwm_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output hbwm_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [hbwm_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   // configuration
   logic [31:0] magic_value_ff, boot_time_ff, boot_grace_ff, stale_limit_ff, alive_grace_ff;
   logic [2:0]  csr_index;
   logic        csr_write;

   // pipeline
   logic              in_valid_ff, in_valid_in;
   hbwm_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   hbwm_pkg::rsp_type out_data_ff;
   logic              accept, advance;

   // trackers
   logic        magic_seen_ff, magic_seen_in;
   logic [31:0] last_progress_ff, last_progress_in;
   logic [31:0] progress_time_ff, progress_time_in;
   logic [31:0] alive_ok_time_ff, alive_ok_time_in;
   logic [31:0] last_uptime_ff, last_uptime_in;
   logic [31:0] uptime_time_ff, uptime_time_in;
   logic [31:0] post_count_ff, post_count_in;

   hbwm_pkg::reason_type reason;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_index)
         hbwm_pkg::REG_MAGIC_VALUE:    csr_prdata = magic_value_ff;
         hbwm_pkg::REG_BOOT_TIME_MS:   csr_prdata = boot_time_ff;
         hbwm_pkg::REG_BOOT_GRACE_MS:  csr_prdata = boot_grace_ff;
         hbwm_pkg::REG_STALE_LIMIT_MS: csr_prdata = stale_limit_ff;
         hbwm_pkg::REG_ALIVE_GRACE_MS: csr_prdata = alive_grace_ff;
         default:                      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_value_ff <= 32'd0;
         boot_time_ff   <= 32'd0;
         boot_grace_ff  <= hbwm_pkg::BOOT_GRACE_RESET;
         stale_limit_ff <= hbwm_pkg::STALE_LIMIT_RESET;
         alive_grace_ff <= hbwm_pkg::ALIVE_GRACE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            hbwm_pkg::REG_MAGIC_VALUE:    magic_value_ff <= csr_pwdata;
            hbwm_pkg::REG_BOOT_TIME_MS:   boot_time_ff   <= csr_pwdata;
            hbwm_pkg::REG_BOOT_GRACE_MS:  boot_grace_ff  <= csr_pwdata;
            hbwm_pkg::REG_STALE_LIMIT_MS: stale_limit_ff <= csr_pwdata;
            hbwm_pkg::REG_ALIVE_GRACE_MS: alive_grace_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // ---------------- judgment ----------------
   always_comb begin
      logic        match;
      logic [31:0] lp_eff, pt_eff, at_eff;
      logic        done;

      match = (in_data_ff.magic_word == magic_value_ff);

      magic_seen_in    = magic_seen_ff;
      last_progress_in = last_progress_ff;
      progress_time_in = progress_time_ff;
      alive_ok_time_in = alive_ok_time_ff;
      last_uptime_in   = last_uptime_ff;
      uptime_time_in   = uptime_time_ff;
      reason           = hbwm_pkg::REASON_OK;
      done             = 1'b0;

      // first sight of the magic snapshots the progress and alive trackers
      if (!magic_seen_ff && match) begin
         lp_eff = in_data_ff.progress_count;
         pt_eff = in_data_ff.now_ms;
         at_eff = in_data_ff.now_ms;
      end else begin
         lp_eff = last_progress_ff;
         pt_eff = progress_time_ff;
         at_eff = alive_ok_time_ff;
      end

      if (!magic_seen_ff && !match) begin
         done = 1'b1;
         if ((in_data_ff.now_ms - boot_time_ff) < boot_grace_ff) begin
            reason = hbwm_pkg::REASON_OK;
         end else begin
            reason = hbwm_pkg::REASON_MAGIC_LOST;
         end
      end else begin
         magic_seen_in    = 1'b1;
         last_progress_in = lp_eff;
         progress_time_in = pt_eff;
         alive_ok_time_in = at_eff;
         if (!match) begin
            done   = 1'b1;
            reason = hbwm_pkg::REASON_MAGIC_LOST;
         end
      end

      if (!done) begin
         if (in_data_ff.progress_count != lp_eff) begin
            last_progress_in = in_data_ff.progress_count;
            progress_time_in = in_data_ff.now_ms;
         end else if ((in_data_ff.now_ms - pt_eff) > stale_limit_ff) begin
            done   = 1'b1;
            reason = hbwm_pkg::REASON_COUNT_FROZE;
         end
      end

      if (!done) begin
         if ((in_data_ff.alive_flags & in_data_ff.need_mask) == in_data_ff.need_mask) begin
            alive_ok_time_in = in_data_ff.now_ms;
         end else if ((in_data_ff.now_ms - at_eff) > alive_grace_ff) begin
            done   = 1'b1;
            reason = hbwm_pkg::REASON_ALIVE_DROP;
         end
      end

      if (!done) begin
         if (in_data_ff.core_uptime != last_uptime_ff) begin
            last_uptime_in = in_data_ff.core_uptime;
            uptime_time_in = in_data_ff.now_ms;
         end else if ((in_data_ff.now_ms - uptime_time_ff) > stale_limit_ff) begin
            reason = hbwm_pkg::REASON_UPTIME_STALL;
         end
      end

      post_count_in = post_count_ff + 32'd1;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         magic_seen_ff    <= 1'b0;
         last_progress_ff <= 32'd0;
         progress_time_ff <= 32'd0;
         alive_ok_time_ff <= 32'd0;
         last_uptime_ff   <= 32'd0;
         uptime_time_ff   <= 32'd0;
         post_count_ff    <= 32'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            magic_seen_ff    <= magic_seen_in;
            last_progress_ff <= last_progress_in;
            progress_time_ff <= progress_time_in;
            alive_ok_time_ff <= alive_ok_time_in;
            last_uptime_ff   <= last_uptime_in;
            uptime_time_ff   <= uptime_time_in;
            post_count_ff    <= post_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff.fault_reason  <= reason;
         out_data_ff.post_sequence <= post_count_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- design/hbwm_checker.sv -----
// ----------------------------------------------------------------------------
// hbwm_checker
// Port-level checks for the heartbeat watchdog monitor, bound to the top.
// ----------------------------------------------------------------------------
module hbwm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input hbwm_pkg::req_type                   req_data,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input hbwm_pkg::rsp_type                   rsp_data,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [hbwm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input logic [31:0]                         csr_pwdata,
   input logic [31:0]                         csr_prdata,
   input logic                                csr_pready
);

   logic [31:0] last_seq_ff;
   logic        rsp_take;
   logic        cfg_touch;

   assign rsp_take  = rsp_valid && !rsp_stall;
   assign cfg_touch = csr_psel && csr_penable && csr_pwrite && (csr_paddr != '0 || csr_pwdata != '0
                      || csr_prdata != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= 32'd0;
      end else if (rsp_take) begin
         last_seq_ff <= rsp_data.post_sequence;
      end
   end

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // each delivered transaction carries the next post sequence number
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> rsp_data.post_sequence == last_seq_ff + 32'd1)
      else $error("post sequence skipped or repeated");

   a_reason_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.fault_reason <= hbwm_pkg::REASON_UPTIME_STALL)
      else $error("fault reason out of range");

   a_no_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      (cfg_touch || req_valid || !cfg_touch) |-> csr_pready)
      else $error("configuration port not ready");

endmodule

bind heartbeat_watchdog_monitor hbwm_checker u_hbwm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_data    (req_data),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_data    (rsp_data),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata),
   .csr_pready  (csr_pready)
);
